// File: design/vrtd_pkg.sv
// ----------------------------------------------------------------------------
// vrtd_pkg
// Shared types, address map constants and the tile row decode function for
// the video RAM with tile row decode.
// ----------------------------------------------------------------------------
package vrtd_pkg;

    localparam int TILE_BYTES_DEF        = 6144;
    localparam int MAP_BYTES_DEF         = 2048;
    localparam int SPRITE_ATTR_BYTES_DEF = 160;

    localparam logic [15:0] TILE_BASE      = 16'h8000;
    localparam logic [15:0] MAP_BASE       = 16'h9800;
    localparam logic [15:0] MAP_LIMIT      = 16'hA000;
    localparam logic [15:0] SPRITE_BASE    = 16'hFE00;
    localparam int          BYTES_PER_TILE = 16'h10;

    localparam int OFF_W = 13;

    typedef enum logic [1:0] {
        REQ_VRAM_RD   = 2'd0,
        REQ_VRAM_WR   = 2'd1,
        REQ_SPRITE_RD = 2'd2,
        REQ_SPRITE_WR = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        RG_NONE   = 2'd0,
        RG_TILE   = 2'd1,
        RG_MAP    = 2'd2,
        RG_SPRITE = 2'd3
    } t_region;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_LOAD  = 2'd2
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_dp_sts;

    // eight 2-bit pixels, leftmost in bits 15:14, high plane bit as msb
    function automatic logic [15:0] interleave_planes(input logic [7:0] lo,
                                                      input logic [7:0] hi);
        logic [15:0] px;
        px = '0;
        for (int i = 0; i < 8; i++) begin
            px[2*i]   = lo[i];
            px[2*i+1] = hi[i];
        end
        return px;
    endfunction

endpackage

// File: design/vrtd_if.sv
// ----------------------------------------------------------------------------
// vrtd_if
// Request and response channels of the video RAM with tile row decode.
// ----------------------------------------------------------------------------
interface vrtd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output req_type, output bus_address,
                    output write_data, input ready);
    modport sink   (input valid, input req_type, input bus_address,
                    input write_data, output ready);
endinterface

interface vrtd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        address_error;
    logic        tile_updated;
    logic [8:0]  tile_index;
    logic [2:0]  tile_row;
    logic [15:0] row_pixels;

    modport source (output valid, output read_data, output address_error,
                    output tile_updated, output tile_index, output tile_row,
                    output row_pixels, input ready);
    modport sink   (input valid, input read_data, input address_error,
                    input tile_updated, input tile_index, input tile_row,
                    input row_pixels, output ready);
endinterface

// File: design/vrtd_ctrl.sv
// ----------------------------------------------------------------------------
// vrtd_ctrl
// Controller: clearing pass after reset, then one word at a time through an
// access step and a result step that waits for room in the output register.
// ----------------------------------------------------------------------------
module vrtd_ctrl
    import vrtd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    a_accept_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_LOAD)
        else $error("accepted word did not move to the result cycle");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result loaded while the output register was held");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> !o_in_ready && !o_cmd.accept)
        else $error("word taken during the clearing pass");

endmodule

// File: design/vrtd_datapath.sv
// ----------------------------------------------------------------------------
// vrtd_datapath
// Address decode, tile/map/sprite/decoded row memories, clear sweep, tile row
// decode and the result register.
// ----------------------------------------------------------------------------
module vrtd_datapath
    import vrtd_pkg::*;
#(
    parameter int TILE_BYTES        = TILE_BYTES_DEF,
    parameter int MAP_BYTES         = MAP_BYTES_DEF,
    parameter int SPRITE_ATTR_BYTES = SPRITE_ATTR_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    vrtd_req_if.sink   i_req,
    vrtd_rsp_if.source o_rsp
);

    localparam int ROW_COUNT = (TILE_BYTES + 1) / 2;
    localparam int TB_W      = $clog2(TILE_BYTES);
    localparam int MB_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int SP_W      = (SPRITE_ATTR_BYTES > 1) ? $clog2(SPRITE_ATTR_BYTES) : 1;
    localparam int RW_W      = $clog2(ROW_COUNT);
    localparam int CLR_A     = (TILE_BYTES > MAP_BYTES) ? TILE_BYTES : MAP_BYTES;
    localparam int CLR_COUNT = (CLR_A > SPRITE_ATTR_BYTES) ? CLR_A : SPRITE_ATTR_BYTES;
    localparam int CLR_W     = $clog2(CLR_COUNT);

    logic [7:0]  r_tile_mem [TILE_BYTES];
    logic [7:0]  r_map_mem  [MAP_BYTES];
    logic [7:0]  r_spr_mem  [SPRITE_ATTR_BYTES];
    logic [15:0] r_row_mem  [ROW_COUNT];

    logic [CLR_W-1:0] r_clr;
    t_region          r_region;
    logic             r_write;
    logic [7:0]       r_data;
    logic [OFF_W-1:0] r_off;
    logic             r_no_partner;
    logic [7:0]       r_tile_q;
    logic [7:0]       r_map_q;
    logic [7:0]       r_spr_q;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic        r_address_error;
    logic        r_tile_updated;
    logic [8:0]  r_tile_index;
    logic [2:0]  r_tile_row;
    logic [15:0] r_row_pixels;

    // address decode
    logic [15:0] tile_off, map_off, spr_off;
    logic        is_write, is_sprite, tile_hit, map_hit, spr_hit, no_partner;
    t_region     region;

    always_comb begin
        tile_off   = i_req.bus_address - TILE_BASE;
        map_off    = i_req.bus_address - MAP_BASE;
        spr_off    = i_req.bus_address - SPRITE_BASE;
        is_write   = i_req.req_type[0];
        is_sprite  = (i_req.req_type == REQ_SPRITE_RD) || (i_req.req_type == REQ_SPRITE_WR);
        tile_hit   = (i_req.bus_address >= TILE_BASE) && (i_req.bus_address < MAP_BASE)
                     && (32'(tile_off) < 32'(TILE_BYTES));
        map_hit    = (i_req.bus_address >= MAP_BASE) && (i_req.bus_address < MAP_LIMIT)
                     && (32'(map_off) < 32'(MAP_BYTES));
        spr_hit    = (i_req.bus_address >= SPRITE_BASE)
                     && (32'(spr_off) < 32'(SPRITE_ATTR_BYTES));
        no_partner = 32'(tile_off | 16'd1) >= 32'(TILE_BYTES);
        if (is_sprite) begin
            region = spr_hit ? RG_SPRITE : RG_NONE;
        end else if (tile_hit) begin
            region = RG_TILE;
        end else if (map_hit) begin
            region = RG_MAP;
        end else begin
            region = RG_NONE;
        end
    end

    // memory port controls
    logic             tile_we, map_we, spr_we, row_we;
    logic [TB_W-1:0]  tile_wa, tile_ra;
    logic [MB_W-1:0]  map_wa;
    logic [SP_W-1:0]  spr_wa;
    logic [RW_W-1:0]  row_wa;
    logic [7:0]       tile_wd, map_wd, spr_wd;
    logic [15:0]      row_wd;
    logic             tile_re, map_re, spr_re;
    logic [7:0]       plane_lo, plane_hi, partner;
    logic [15:0]      pixels;

    always_comb begin
        partner  = r_no_partner ? 8'd0 : r_tile_q;
        plane_lo = r_off[0] ? partner : r_data;
        plane_hi = r_off[0] ? r_data : partner;
        pixels   = interleave_planes(plane_lo, plane_hi);

        if (i_cmd.clear) begin
            tile_we = 32'(r_clr) < 32'(TILE_BYTES);
            map_we  = 32'(r_clr) < 32'(MAP_BYTES);
            spr_we  = 32'(r_clr) < 32'(SPRITE_ATTR_BYTES);
            row_we  = 32'(r_clr) < 32'(ROW_COUNT);
            tile_wa = r_clr[TB_W-1:0];
            map_wa  = r_clr[MB_W-1:0];
            spr_wa  = r_clr[SP_W-1:0];
            row_wa  = r_clr[RW_W-1:0];
            tile_wd = 8'd0;
            map_wd  = 8'd0;
            spr_wd  = 8'd0;
            row_wd  = 16'd0;
        end else begin
            tile_we = i_cmd.accept && is_write && (region == RG_TILE);
            map_we  = i_cmd.accept && is_write && (region == RG_MAP);
            spr_we  = i_cmd.accept && is_write && (region == RG_SPRITE);
            row_we  = i_cmd.finish && r_write && (r_region == RG_TILE);
            tile_wa = tile_off[TB_W-1:0];
            map_wa  = map_off[MB_W-1:0];
            spr_wa  = spr_off[SP_W-1:0];
            row_wa  = r_off[RW_W:1];
            tile_wd = i_req.write_data;
            map_wd  = i_req.write_data;
            spr_wd  = i_req.write_data;
            row_wd  = pixels;
        end

        // a tile write reads its partner byte, a tile read the byte itself
        tile_re = i_cmd.accept && (region == RG_TILE) && !(is_write && no_partner);
        tile_ra = is_write ? (tile_off[TB_W-1:0] ^ TB_W'(1)) : tile_off[TB_W-1:0];
        map_re  = i_cmd.accept && !is_write && (region == RG_MAP);
        spr_re  = i_cmd.accept && !is_write && (region == RG_SPRITE);
    end

    always_ff @(posedge i_clk) begin
        if (tile_we) begin
            r_tile_mem[tile_wa] <= tile_wd;
        end
        if (tile_re) begin
            r_tile_q <= r_tile_mem[tile_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= r_map_mem[map_off[MB_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (spr_we) begin
            r_spr_mem[spr_wa] <= spr_wd;
        end
        if (spr_re) begin
            r_spr_q <= r_spr_mem[spr_off[SP_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_wa] <= row_wd;
        end
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear && !o_sts.clear_done) begin
            r_clr <= r_clr + CLR_W'(1);
        end
    end

    // access held for the result cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_region     <= region;
            r_write      <= is_write;
            r_data       <= i_req.write_data;
            r_off        <= tile_off[OFF_W-1:0];
            r_no_partner <= no_partner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_address_error <= r_region == RG_NONE;
            r_tile_updated  <= r_write && (r_region == RG_TILE);
            if (r_write) begin
                r_read_data <= 8'd0;
            end else begin
                case (r_region)
                    RG_TILE:   r_read_data <= r_tile_q;
                    RG_MAP:    r_read_data <= r_map_q;
                    RG_SPRITE: r_read_data <= r_spr_q;
                    default:   r_read_data <= 8'd0;
                endcase
            end
            if (r_write && (r_region == RG_TILE)) begin
                r_tile_index <= r_off[OFF_W-1:4];
                r_tile_row   <= r_off[3:1];
                r_row_pixels <= pixels;
            end else begin
                r_tile_index <= 9'd0;
                r_tile_row   <= 3'd0;
                r_row_pixels <= 16'd0;
            end
        end
    end

    assign o_sts.clear_done = r_clr == CLR_W'(CLR_COUNT - 1);
    assign o_sts.out_free   = !r_out_valid || o_rsp.ready;

    assign i_req.ready         = i_cmd.accept;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_read_data;
    assign o_rsp.address_error = r_address_error;
    assign o_rsp.tile_updated  = r_tile_updated;
    assign o_rsp.tile_index    = r_tile_index;
    assign o_rsp.tile_row      = r_tile_row;
    assign o_rsp.row_pixels    = r_row_pixels;

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_address_error |-> r_read_data == 8'd0 && !r_tile_updated)
        else $error("address error with read data or decoded row");

    a_no_row_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_tile_updated |->
            r_row_pixels == 16'd0 && r_tile_index == 9'd0 && r_tile_row == 3'd0)
        else $error("row fields set without a decoded row");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_out_valid && !o_rsp.ready) |-> r_out_valid && $stable(r_row_pixels)
            && $stable(r_read_data))
        else $error("held result changed");

    a_row_write_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_we && !i_cmd.clear |-> r_region == RG_TILE && r_write)
        else $error("decoded row written for a non-tile access");

endmodule

// File: design/video_ram_with_tile_row_decode.sv
// ----------------------------------------------------------------------------
// video_ram_with_tile_row_decode
// Video RAM, background map and sprite attribute store with tile row decode.
// ----------------------------------------------------------------------------
// Each request word passes an access step and a result step: in the first the
// address is decoded, a write is stored and the addressed byte (or, for a tile
// write, its partner byte) is read from its memory; in the second the tile row
// of a tile write is decoded and written to the decoded row store, and the
// response word is loaded. A new request is taken only once the previous one's
// response word is loaded; a stalled response holds the block in its result
// step. After reset the block sweeps all memories to zero, one entry a cycle,
// covering max(TILE_BYTES, MAP_BYTES, SPRITE_ATTR_BYTES) entries (6144 at the
// default sizes) before the first request is taken.
module video_ram_with_tile_row_decode
    import vrtd_pkg::*;
#(
    parameter int TILE_BYTES        = TILE_BYTES_DEF,
    parameter int MAP_BYTES         = MAP_BYTES_DEF,
    parameter int SPRITE_ATTR_BYTES = SPRITE_ATTR_BYTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    vrtd_req_if.sink   i_req,
    vrtd_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    vrtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vrtd_datapath #(
        .TILE_BYTES        (TILE_BYTES),
        .MAP_BYTES         (MAP_BYTES),
        .SPRITE_ATTR_BYTES (SPRITE_ATTR_BYTES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    a_ready_means_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready && i_req.valid |-> cmd.accept && i_req.ready)
        else $error("ready and valid without an accept");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the video RAM with tile row decode through its request and response
// channels. A shadow copy of the tile, map and sprite attribute stores
// predicts every response word, including the decoded tile row. A short
// directed pass covers region edges, plane pairing and bad addresses. Random
// bus accesses follow, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import vrtd_pkg::*;

    localparam int N_RANDOM     = 1880;
    localparam int STEADY_TAIL  = 150;
    localparam int IDLE_LIMIT   = 50000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        address_error;
        logic        tile_updated;
        logic [8:0]  tile_index;
        logic [2:0]  tile_row;
        logic [15:0] row_pixels;
    } t_vram_rsp;

    class vram_scoreboard;
        logic [7:0]  tile_mem [TILE_BYTES_DEF];
        logic [7:0]  map_mem [MAP_BYTES_DEF];
        logic [7:0]  sprite_mem [SPRITE_ATTR_BYTES_DEF];
        logic [15:0] row_mem [(TILE_BYTES_DEF + 1) / 2];
        t_vram_rsp   pending_rsp [$];
        int          errors;

        function new();
            foreach (tile_mem[i]) tile_mem[i] = '0;
            foreach (map_mem[i]) map_mem[i] = '0;
            foreach (sprite_mem[i]) sprite_mem[i] = '0;
            foreach (row_mem[i]) row_mem[i] = '0;
            errors = 0;
        endfunction

        // leftmost pixel first, high plane bit above low plane bit
        function logic [15:0] plane_mix(logic [7:0] lo, logic [7:0] hi);
            logic [15:0] px;
            px = '0;
            for (int b = 7; b >= 0; b--) px = {px[13:0], hi[b], lo[b]};
            return px;
        endfunction

        function void apply_access(t_req_type kind, logic [15:0] addr,
                                   logic [7:0] data);
            t_vram_rsp want;
            int        a;
            int        off;
            logic [7:0] lo;
            logic [7:0] hi;
            want = '0;
            a = int'(addr);
            if (kind == REQ_SPRITE_RD || kind == REQ_SPRITE_WR) begin
                off = a - int'(SPRITE_BASE);
                if (off >= 0 && off < SPRITE_ATTR_BYTES_DEF) begin
                    if (kind == REQ_SPRITE_WR) sprite_mem[off] = data;
                    else want.read_data = sprite_mem[off];
                end else begin
                    want.address_error = 1'b1;
                end
            end else if (a >= int'(TILE_BASE) && a < int'(MAP_BASE) &&
                         a - int'(TILE_BASE) < TILE_BYTES_DEF) begin
                off = a - int'(TILE_BASE);
                if (kind == REQ_VRAM_WR) begin
                    tile_mem[off] = data;
                    lo = tile_mem[off & ~1];
                    hi = ((off | 1) < TILE_BYTES_DEF) ? tile_mem[off | 1] : 8'h00;
                    want.row_pixels = plane_mix(lo, hi);
                    row_mem[off >> 1] = want.row_pixels;
                    want.tile_updated = 1'b1;
                    want.tile_index = 9'(off / BYTES_PER_TILE);
                    want.tile_row = 3'((off % BYTES_PER_TILE) / 2);
                end else begin
                    want.read_data = tile_mem[off];
                end
            end else if (a >= int'(MAP_BASE) && a < int'(MAP_LIMIT) &&
                         a - int'(MAP_BASE) < MAP_BYTES_DEF) begin
                off = a - int'(MAP_BASE);
                if (kind == REQ_VRAM_WR) map_mem[off] = data;
                else want.read_data = map_mem[off];
            end else begin
                want.address_error = 1'b1;
            end
            pending_rsp.push_back(want);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_vram_rsp got);
            t_vram_rsp want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response word, expected none, actual 0x%0h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            field_check("read_data", want.read_data, got.read_data);
            field_check("address_error", want.address_error, got.address_error);
            field_check("tile_updated", want.tile_updated, got.tile_updated);
            field_check("tile_index", want.tile_index, got.tile_index);
            field_check("tile_row", want.tile_row, got.tile_row);
            field_check("row_pixels", want.row_pixels, got.row_pixels);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   stall_cycles;

    vram_scoreboard scoreboard;

    vrtd_req_if req_bus ();
    vrtd_rsp_if rsp_bus ();

    video_ram_with_tile_row_decode u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && scoreboard != null) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                scoreboard.check_response({rsp_bus.read_data, rsp_bus.address_error,
                                           rsp_bus.tile_updated, rsp_bus.tile_index,
                                           rsp_bus.tile_row, rsp_bus.row_pixels});
            end
            if (req_bus.valid && req_bus.ready) begin
                scoreboard.apply_access(t_req_type'(req_bus.req_type),
                                        req_bus.bus_address, req_bus.write_data);
            end
        end
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // response side back-pressure
    initial begin
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!steady && $urandom_range(0, 2) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    task automatic send_word(t_req_type kind, logic [15:0] addr, logic [7:0] data);
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= kind;
        req_bus.bus_address <= addr;
        req_bus.write_data  <= data;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    task automatic pause_sender();
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge i_clk);
    endtask

    task automatic send_random();
        int          pick;
        int          off;
        t_req_type   kind;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // narrow window half the time so plane partners get paired often
            off = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                       : $urandom_range(0, TILE_BYTES_DEF - 1);
            addr = 16'(int'(TILE_BASE) + off);
            kind = $urandom_range(0, 1) ? REQ_VRAM_WR : REQ_VRAM_RD;
        end else if (pick < 60) begin
            off = $urandom_range(0, 1) ? $urandom_range(0, 31)
                                       : $urandom_range(0, MAP_BYTES_DEF - 1);
            addr = 16'(int'(MAP_BASE) + off);
            kind = $urandom_range(0, 1) ? REQ_VRAM_WR : REQ_VRAM_RD;
        end else if (pick < 82) begin
            addr = 16'(int'(SPRITE_BASE) + $urandom_range(0, SPRITE_ATTR_BYTES_DEF - 1));
            kind = $urandom_range(0, 1) ? REQ_SPRITE_WR : REQ_SPRITE_RD;
        end else begin
            addr = 16'($urandom);
            kind = t_req_type'($urandom_range(0, 3));
        end
        send_word(kind, addr, 8'($urandom));
    endtask

    initial begin
        int gap_odds;
        gap_odds = 0;
        steady = 1'b0;
        stall_cycles = 0;
        scoreboard = new();
        req_bus.valid       <= 1'b0;
        req_bus.req_type    <= REQ_VRAM_RD;
        req_bus.bus_address <= '0;
        req_bus.write_data  <= '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plane pairing at both ends of the tile area
        send_word(REQ_VRAM_RD, 16'h8000, 8'h00);
        send_word(REQ_VRAM_WR, 16'h8000, 8'hFF);
        send_word(REQ_VRAM_WR, 16'h8001, 8'hA5);
        send_word(REQ_VRAM_RD, 16'h8001, 8'hFF);
        send_word(REQ_VRAM_WR, 16'h97FF, 8'h3C);
        send_word(REQ_VRAM_WR, 16'h97FE, 8'hFF);
        send_word(REQ_VRAM_RD, 16'h97FE, 8'h00);
        // map and sprite edges
        send_word(REQ_VRAM_WR, 16'h9800, 8'h5A);
        send_word(REQ_VRAM_WR, 16'h9FFF, 8'hFF);
        send_word(REQ_VRAM_RD, 16'h9800, 8'h00);
        send_word(REQ_VRAM_RD, 16'h9FFF, 8'h00);
        send_word(REQ_SPRITE_WR, 16'hFE00, 8'h81);
        send_word(REQ_SPRITE_WR, 16'hFE9F, 8'h7E);
        send_word(REQ_SPRITE_RD, 16'hFE00, 8'h00);
        send_word(REQ_SPRITE_RD, 16'hFE9F, 8'h00);
        // addresses outside the selected region
        send_word(REQ_VRAM_RD, 16'h7FFF, 8'h00);
        send_word(REQ_VRAM_WR, 16'hA000, 8'hFF);
        send_word(REQ_VRAM_WR, 16'h0000, 8'hFF);
        send_word(REQ_VRAM_RD, 16'hFFFF, 8'h00);
        send_word(REQ_VRAM_RD, 16'hFE00, 8'h00);
        send_word(REQ_SPRITE_RD, 16'hFDFF, 8'h00);
        send_word(REQ_SPRITE_WR, 16'hFEA0, 8'hFF);
        send_word(REQ_SPRITE_RD, 16'hFEA0, 8'h00);
        send_word(REQ_SPRITE_RD, 16'h8000, 8'h00);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) gap_odds = $urandom_range(0, 3);
            if (i >= N_RANDOM - STEADY_TAIL) steady = 1'b1;
            if (!steady && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
                pause_sender();
            end
            send_random();
        end
        req_bus.valid <= 1'b0;

        while (scoreboard.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.pending_rsp.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
